[hdl/hmbdj_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hmbdj_pkg
// Shared types, address map and codes for the handheld upper memory bus.
// ----------------------------------------------------------------------------
package hmbdj_pkg;

    // bus actions
    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;
    localparam logic [1:0] ACT_NOP   = 2'd3;

    // special register selects
    localparam logic [2:0] SP_NONE = 3'd0;
    localparam logic [2:0] SP_JOY  = 3'd1;
    localparam logic [2:0] SP_DIV  = 3'd2;
    localparam logic [2:0] SP_DMA  = 3'd3;
    localparam logic [2:0] SP_LY   = 3'd4;
    localparam logic [2:0] SP_IF   = 3'd5;

    // address map
    localparam logic [15:0] ADDR_CART_TOP  = 16'h7FFF;
    localparam logic [15:0] ADDR_XRAM_LO   = 16'hA000;
    localparam logic [15:0] ADDR_XRAM_HI   = 16'hBFFF;
    localparam logic [15:0] ADDR_HRAM      = 16'hFF80;
    localparam logic [15:0] ADDR_JOYP      = 16'hFF00;
    localparam logic [15:0] ADDR_DIV       = 16'hFF04;
    localparam logic [15:0] ADDR_IF        = 16'hFF0F;
    localparam logic [15:0] ADDR_LY        = 16'hFF44;
    localparam logic [15:0] ADDR_DMA       = 16'hFF46;

    // internal store
    localparam int MEM_DEPTH = 32768;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam logic [MEM_AW-1:0] MEM_OAM_BASE = 15'h7E00;

    // DMA
    localparam logic [7:0] DMA_LENGTH   = 8'd160;
    localparam logic [7:0] DMA_RAM_PAGE = 8'h80;

    // register bit masks
    localparam logic [7:0] JOYP_FORCE = 8'hCF;
    localparam logic [7:0] JOYP_SEL   = 8'h30;
    localparam logic [7:0] IF_JOYPAD  = 8'h10;
    localparam logic [7:0] BLOCK_DATA = 8'hFF;
    localparam logic [2:0] IRQ_NONE   = 3'd5;

    // command queue
    localparam int QDEPTH = 2;
    localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [7:0]  buttons;
        logic [7:0]  cart_read_data;
        logic        is_cart;
        logic        below_hram;
        logic [2:0]  special;
    } cmd_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       to_cartridge;
        logic       blocked;
        logic       dma_busy;
        logic [2:0] pending_irq;
    } result_t;

endpackage
`default_nettype wire

[hdl/hmbdj_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hmbdj_front
// Input beat intake: unpacks the beat and decodes address class and
// special register select into a queue command.
// ----------------------------------------------------------------------------
module hmbdj_front
    import hmbdj_pkg::*;
(
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // address, write_data, buttons,
                                        // cart_ram_enabled, cart_read_data
    input  wire logic [1:0]  s_tuser,   // action
    input  wire logic        clearing,
    input  wire logic        q_full,
    output logic             push,
    output cmd_t             cmd
);

    logic [15:0] addr;
    logic        ram_on;
    logic        in_xram;

    assign addr    = s_tdata[15:0];
    assign ram_on  = s_tdata[32];
    assign in_xram = (addr >= ADDR_XRAM_LO) && (addr <= ADDR_XRAM_HI);

    assign s_tready = !clearing && !q_full;
    assign push     = s_tvalid && s_tready;

    always_comb begin
        cmd.action         = s_tuser;
        cmd.address        = addr;
        cmd.write_data     = s_tdata[23:16];
        cmd.buttons        = s_tdata[31:24];
        cmd.cart_read_data = s_tdata[40:33];
        cmd.is_cart        = (addr <= ADDR_CART_TOP) || (in_xram && ram_on);
        cmd.below_hram     = addr < ADDR_HRAM;
        case (addr)
            ADDR_JOYP: cmd.special = SP_JOY;
            ADDR_DIV:  cmd.special = SP_DIV;
            ADDR_DMA:  cmd.special = SP_DMA;
            ADDR_LY:   cmd.special = SP_LY;
            ADDR_IF:   cmd.special = SP_IF;
            default:   cmd.special = SP_NONE;
        endcase
    end

    logic unused_pad;
    assign unused_pad = ^s_tdata[47:41];

endmodule
`default_nettype wire

[hdl/hmbdj_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hmbdj_queue
// Short command queue between decode and execution.
// ----------------------------------------------------------------------------
module hmbdj_queue
    import hmbdj_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      head_valid,
    output cmd_t      head
);

    cmd_t             entry_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]     count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = count_reg == (QAW+1)'(QDEPTH);
    assign head_valid = count_reg != '0;
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QDEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QDEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

[hdl/hmbdj_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hmbdj_back
// Execution: upper memory store, joypad and IF registers, OAM DMA engine,
// and the result register.
// ----------------------------------------------------------------------------
module hmbdj_back
    import hmbdj_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic q_valid,
    input  wire cmd_t cmd,
    output logic      pop,
    output logic      clearing,
    output logic      out_valid,
    input  wire logic out_ready,
    output result_t   out_data
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_RDATA = 2'd2;

    logic [7:0]        mem [MEM_DEPTH];
    logic [7:0]        rd_reg;

    logic [1:0]        state_reg, state_next;
    logic [MEM_AW-1:0] clr_reg, clr_next;
    logic [7:0]        joy_reg, joy_next;
    logic [7:0]        if_reg, if_next;
    logic [7:0]        page_reg, page_next;
    logic [7:0]        count_reg, count_next;
    logic              run_reg, run_next;
    logic              out_valid_reg;
    result_t           out_reg;

    logic              mem_we, mem_re;
    logic [MEM_AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]        mem_wdata;

    logic              can_emit, emit;
    logic              dma_adv;
    logic [7:0]        dma_val;
    logic [15:0]       dma_src;
    logic              src_from_mem;
    logic              blk;
    logic              need_rd;
    logic [7:0]        joy_rd;
    logic [7:0]        count_inc;
    result_t           res;

    assign clearing  = state_reg == S_CLEAR;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign can_emit  = !out_valid_reg || out_ready;

    assign dma_src      = {page_reg, count_reg};
    assign src_from_mem = (page_reg >= DMA_RAM_PAGE) && (dma_src != ADDR_JOYP)
                          && (dma_src != ADDR_IF);
    assign blk          = run_reg && cmd.below_hram;
    assign count_inc    = count_reg + 8'd1;

    always_comb begin
        joy_rd = joy_reg | JOYP_FORCE;
        if (!joy_rd[4]) begin
            joy_rd = joy_rd & ~{4'h0, cmd.buttons[3:0]};
        end
        if (!joy_rd[5]) begin
            joy_rd = joy_rd & ~{4'h0, cmd.buttons[7:4]};
        end
    end

    always_comb begin
        need_rd = 1'b0;
        case (cmd.action)
            ACT_READ: need_rd = !blk && !cmd.is_cart && (cmd.special != SP_JOY)
                                && (cmd.special != SP_IF);
            ACT_TICK: need_rd = run_reg && src_from_mem;
            default:  need_rd = 1'b0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        joy_next   = joy_reg;
        if_next    = if_reg;
        page_next  = page_reg;
        count_next = count_reg;
        run_next   = run_reg;
        mem_we     = 1'b0;
        mem_waddr  = cmd.address[MEM_AW-1:0];
        mem_wdata  = cmd.write_data;
        mem_re     = 1'b0;
        mem_raddr  = cmd.address[MEM_AW-1:0];
        emit       = 1'b0;
        pop        = 1'b0;
        dma_adv    = 1'b0;
        dma_val    = 8'h00;
        res        = '0;

        case (state_reg)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = 8'h00;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == {MEM_AW{1'b1}}) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (q_valid) begin
                    if (need_rd) begin
                        mem_re = 1'b1;
                        if (cmd.action == ACT_TICK) begin
                            mem_raddr = dma_src[MEM_AW-1:0];
                        end
                        state_next = S_RDATA;
                    end else if (can_emit) begin
                        emit = 1'b1;
                        case (cmd.action)
                            ACT_READ: begin
                                if (blk) begin
                                    res.read_data = BLOCK_DATA;
                                    res.blocked   = 1'b1;
                                end else if (cmd.is_cart) begin
                                    res.read_data    = cmd.cart_read_data;
                                    res.to_cartridge = 1'b1;
                                end else if (cmd.special == SP_JOY) begin
                                    res.read_data = joy_rd;
                                    joy_next      = joy_rd;
                                    if (joy_rd[3:0] != joy_reg[3:0]) begin
                                        if_next = if_reg | IF_JOYPAD;
                                    end
                                end else begin
                                    res.read_data = if_reg;
                                end
                            end
                            ACT_WRITE: begin
                                if (blk) begin
                                    res.blocked = 1'b1;
                                end else if (cmd.is_cart) begin
                                    res.to_cartridge = 1'b1;
                                end else begin
                                    case (cmd.special)
                                        SP_JOY: joy_next = (joy_reg & JOYP_FORCE)
                                                           | (cmd.write_data & JOYP_SEL);
                                        SP_DIV: begin
                                            mem_we    = 1'b1;
                                            mem_wdata = 8'h00;
                                        end
                                        SP_DMA: begin
                                            page_next  = cmd.write_data;
                                            count_next = 8'd0;
                                            run_next   = 1'b1;
                                        end
                                        SP_LY:  mem_we = 1'b0;
                                        SP_IF:  if_next = cmd.write_data;
                                        default: mem_we = 1'b1;
                                    endcase
                                end
                            end
                            ACT_TICK: begin
                                if (run_reg) begin
                                    dma_adv = 1'b1;
                                    if (page_reg < DMA_RAM_PAGE) begin
                                        dma_val = 8'h00;
                                    end else if (dma_src == ADDR_JOYP) begin
                                        dma_val = joy_reg;
                                    end else begin
                                        dma_val = if_reg;
                                    end
                                end
                            end
                            default: emit = 1'b1;
                        endcase
                    end
                end
            end
            S_RDATA: begin
                if (can_emit) begin
                    emit       = 1'b1;
                    state_next = S_EXEC;
                    if (cmd.action == ACT_TICK) begin
                        dma_adv = 1'b1;
                        dma_val = rd_reg;
                    end else begin
                        res.read_data = rd_reg;
                    end
                end
            end
            default: state_next = S_CLEAR;
        endcase

        if (dma_adv) begin
            mem_we     = 1'b1;
            mem_waddr  = MEM_OAM_BASE + {{(MEM_AW-8){1'b0}}, count_reg};
            mem_wdata  = dma_val;
            count_next = count_inc;
            if (count_inc >= DMA_LENGTH) begin
                run_next = 1'b0;
            end
        end

        if (emit) begin
            pop = 1'b1;
        end

        res.dma_busy = run_next;
        if (if_next[0]) begin
            res.pending_irq = 3'd0;
        end else if (if_next[1]) begin
            res.pending_irq = 3'd1;
        end else if (if_next[2]) begin
            res.pending_irq = 3'd2;
        end else if (if_next[3]) begin
            res.pending_irq = 3'd3;
        end else if (if_next[4]) begin
            res.pending_irq = 3'd4;
        end else begin
            res.pending_irq = IRQ_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            joy_reg       <= 8'h00;
            if_reg        <= 8'h00;
            page_reg      <= 8'h00;
            count_reg     <= 8'h00;
            run_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            joy_reg   <= joy_next;
            if_reg    <= if_next;
            page_reg  <= page_next;
            count_reg <= count_next;
            run_reg   <= run_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_reg <= mem[mem_raddr];
        end
    end

endmodule
`default_nettype wire

[hdl/handheld_memory_bus_dma_joypad_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// handheld_memory_bus_dma_joypad_top
// Upper-half memory bus with OAM DMA and joypad register.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                              | tuser
//  s_      | in  | address, write_data, buttons, cart_ram_enabled, | action
//          |     | cart_read_data                                  |
//  m_      | out | read_data, to_cartridge, blocked, dma_busy,     | -
//          |     | pending_irq                                     |
//
//  A beat is done in S_EXEC once the output register can take its result; store
//  reads and DMA ticks from a store source go on via S_RDATA (single-port store:
//  read, then write). After reset S_CLEAR zeroes the store with s_tready low.
//  A 2-entry command queue and the output register let s_ and m_ stall apart.
// ----------------------------------------------------------------------------
module handheld_memory_bus_dma_joypad_top
    import hmbdj_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // address[15:0], write_data[23:16],
                                        // buttons[31:24], cart_ram_enabled[32],
                                        // cart_read_data[40:33]
    input  wire logic [1:0]  s_tuser,   // action[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // read_data[7:0], to_cartridge[8],
                                        // blocked[9], dma_busy[10],
                                        // pending_irq[13:11]
);

    logic    clearing;
    logic    q_full;
    logic    push;
    cmd_t    push_cmd;
    logic    pop;
    logic    head_valid;
    cmd_t    head;
    result_t res;

    hmbdj_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .clearing (clearing),
        .q_full   (q_full),
        .push     (push),
        .cmd      (push_cmd)
    );

    hmbdj_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    hmbdj_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (head_valid),
        .cmd       (head),
        .pop       (pop),
        .clearing  (clearing),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    assign m_tdata = {2'b00, res.pending_irq, res.dma_busy, res.blocked,
                      res.to_cartridge, res.read_data};

endmodule
`default_nettype wire

[tb/sv/handheld_memory_bus_dma_joypad_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handheld_memory_bus_dma_joypad_top_tb
// Self-checking bench for the upper memory bus with OAM DMA and joypad.
// A bus model tracks the byte store, the joypad and IF registers and the DMA
// engine. It predicts every result beat from the accepted input beats. The
// stimulus has a short directed part, then random episodes. Some episodes are
// full DMA runs with blocked accesses between the ticks; others are bus
// traffic over the whole address map. Both channels stall at random.
// ----------------------------------------------------------------------------
import hmbdj_pkg::*;

typedef struct packed {
    logic [1:0]  action;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  buttons;
    logic        ram_on;
    logic [7:0]  cart_data;
} bus_access_t;

class bus_scoreboard;
    bit [7:0]  store [MEM_DEPTH];
    bit [7:0]  dma_page;
    bit [7:0]  dma_cnt;
    bit        dma_on;
    result_t   expected_responses[$];
    int        n_checked;
    int        mismatches;

    function bit [7:0] peek(logic [15:0] a);
        return store[a[MEM_AW-1:0]];
    endfunction

    function void poke(logic [15:0] a, bit [7:0] v);
        store[a[MEM_AW-1:0]] = v;
    endfunction

    function int pending();
        return expected_responses.size();
    endfunction

    // runs one accepted access against the model, queues the result it causes
    function void note_access(bus_access_t a);
        result_t    r;
        bit [7:0]   jp;
        bit [3:0]   old_nib;
        bit [15:0]  src;
        bit [7:0]   flags;
        int         i;
        r = '0;
        r.pending_irq = IRQ_NONE;
        if (a.action == ACT_READ || a.action == ACT_WRITE) begin
            if (dma_on && a.address < ADDR_HRAM) begin
                r.blocked = 1'b1;
                if (a.action == ACT_READ) r.read_data = BLOCK_DATA;
            end else if (a.address <= ADDR_CART_TOP ||
                         (a.address >= ADDR_XRAM_LO && a.address <= ADDR_XRAM_HI &&
                          a.ram_on)) begin
                r.to_cartridge = 1'b1;
                if (a.action == ACT_READ) r.read_data = a.cart_data;
            end else if (a.action == ACT_READ) begin
                if (a.address == ADDR_JOYP) begin
                    jp = peek(ADDR_JOYP);
                    old_nib = jp[3:0];
                    jp = jp | JOYP_FORCE;
                    if (!jp[4]) jp = jp & ~{4'h0, a.buttons[3:0]};
                    if (!jp[5]) jp = jp & ~{4'h0, a.buttons[7:4]};
                    poke(ADDR_JOYP, jp);
                    if (jp[3:0] != old_nib) poke(ADDR_IF, peek(ADDR_IF) | IF_JOYPAD);
                    r.read_data = jp;
                end else begin
                    r.read_data = peek(a.address);
                end
            end else begin
                case (a.address)
                    ADDR_JOYP: poke(ADDR_JOYP, (peek(ADDR_JOYP) & ~JOYP_SEL) |
                                               (a.write_data & JOYP_SEL));
                    ADDR_DIV:  poke(ADDR_DIV, 8'h00);
                    ADDR_DMA: begin
                        dma_page = a.write_data;
                        dma_cnt  = 8'h00;
                        dma_on   = 1'b1;
                    end
                    ADDR_LY: ;
                    default:   poke(a.address, a.write_data);
                endcase
            end
        end else if (a.action == ACT_TICK && dma_on) begin
            src = {dma_page, 8'h00} + {8'h00, dma_cnt};
            store[MEM_OAM_BASE + dma_cnt] = src[15] ? store[src[MEM_AW-1:0]] : 8'h00;
            dma_cnt++;
            if (dma_cnt >= DMA_LENGTH) dma_on = 1'b0;
        end
        r.dma_busy = dma_on;
        flags = peek(ADDR_IF);
        for (i = 4; i >= 0; i--) begin
            if (flags[i]) r.pending_irq = i[2:0];
        end
        expected_responses.push_back(r);
    endfunction

    function void check_result(logic [15:0] beat);
        result_t    want;
        logic [7:0] rd;
        logic       cart;
        logic       blk;
        logic       busy;
        logic [2:0] irq;
        rd   = beat[7:0];
        cart = beat[8];
        blk  = beat[9];
        busy = beat[10];
        irq  = beat[13:11];
        n_checked++;
        if (expected_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("tb: result beat %0d with nothing outstanding, data %h",
                         n_checked, beat);
            return;
        end
        want = expected_responses.pop_front();
        if (rd !== want.read_data || cart !== want.to_cartridge || blk !== want.blocked ||
            busy !== want.dma_busy || irq !== want.pending_irq) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("tb: result beat %0d expected rd=%h cart=%b blk=%b busy=%b irq=%0d",
                         n_checked, want.read_data, want.to_cartridge, want.blocked,
                         want.dma_busy, want.pending_irq);
                $display("tb: result beat %0d got      rd=%h cart=%b blk=%b busy=%b irq=%0d",
                         n_checked, rd, cart, blk, busy, irq);
            end
        end
    endfunction
endclass

module handheld_memory_bus_dma_joypad_top_tb;

    localparam int RANDOM_ITEMS = 850;
    localparam int LONG_HOLD    = 400;
    localparam int SETTLE       = 20;
    localparam int RUN_LIMIT_NS = 5_000_000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = ACT_READ;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    bus_scoreboard sb;
    int            n_sent;
    bit            tx_burst;
    bit            held_off;

    handheld_memory_bus_dma_joypad_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (tx_burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] rand_addr();
        case ($urandom_range(0, 9))
            0: rand_addr = 16'($urandom_range(0, 16'h7FFF));
            1: rand_addr = 16'($urandom_range(16'h8000, 16'h9FFF));
            2: rand_addr = 16'($urandom_range(16'hA000, 16'hBFFF));
            3: rand_addr = 16'($urandom_range(16'hC000, 16'hFDFF));
            4: rand_addr = 16'(16'hC000 + $urandom_range(0, 7));
            5: rand_addr = 16'(16'hA000 + $urandom_range(0, 7));
            6: rand_addr = 16'($urandom_range(16'hFE00, 16'hFF7F));
            7: begin
                case ($urandom_range(0, 3))
                    0: rand_addr = ADDR_JOYP;
                    1: rand_addr = ADDR_DIV;
                    2: rand_addr = ADDR_IF;
                    default: rand_addr = ADDR_LY;
                endcase
            end
            8: rand_addr = 16'($urandom_range(16'hFF80, 16'hFFFF));
            default: rand_addr = 16'(16'hFE00 + $urandom_range(0, 159));
        endcase
    endfunction

    // holds the beat until accepted; valid stays high into a back-to-back beat
    task automatic issue(input logic [1:0] act, input logic [15:0] addr,
                         input logic [7:0] wd, input logic [7:0] btn,
                         input logic ram, input logic [7:0] cd);
        bus_access_t a;
        int          gap;
        a.action     = act;
        a.address    = addr;
        a.write_data = wd;
        a.buttons    = btn;
        a.ram_on     = ram;
        a.cart_data  = cd;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {7'b0, cd, ram, btn, wd, addr};
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_access(a);
        n_sent++;
    endtask

    task automatic rand_issue(input logic [1:0] act, input logic [15:0] addr,
                              input logic [7:0] wd);
        issue(act, addr, wd, 8'($urandom), 1'($urandom_range(0, 1)), 8'($urandom));
    endtask

    task automatic drain_dma();
        while (sb.dma_on) begin
            if ($urandom_range(0, 99) < 80)
                rand_issue(ACT_TICK, 16'($urandom), 8'($urandom));
            else
                rand_issue(2'($urandom_range(0, 1)), rand_addr(), 8'($urandom));
        end
    endtask

    task automatic dma_episode();
        logic [7:0] page;
        logic [7:0] offs;
        drain_dma();
        case ($urandom_range(0, 5))
            0: page = 8'($urandom_range(0, 8'h7F));
            1: page = $urandom_range(0, 1) ? 8'hFE : 8'hFF;
            default: page = 8'($urandom_range(8'h80, 8'hFD));
        endcase
        if (page >= 8'h80 && page != 8'hFF) begin
            repeat ($urandom_range(2, 8)) begin
                offs = 8'($urandom_range(0, DMA_LENGTH - 1));
                rand_issue(ACT_WRITE, {page, offs}, 8'($urandom));
            end
        end
        rand_issue(ACT_WRITE, ADDR_DMA, page);
        drain_dma();
        repeat (4) rand_issue(ACT_READ, 16'(16'hFE00 + $urandom_range(0, DMA_LENGTH - 1)),
                              8'h00);
    endtask

    task automatic traffic_episode();
        logic [15:0] addr;
        logic [7:0]  wd;
        int          r;
        repeat ($urandom_range(15, 40)) begin
            r    = $urandom_range(0, 99);
            addr = rand_addr();
            wd   = 8'($urandom);
            if (addr == ADDR_IF && $urandom_range(0, 1)) wd = 8'h00;
            if (r < 45)
                rand_issue(ACT_READ, addr, wd);
            else if (r < 85)
                rand_issue(ACT_WRITE, addr, wd);
            else
                rand_issue(ACT_TICK, addr, wd);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // result side: random stalls, burst stretches, and one long hold-off
    initial begin : rx_side
        int  cyc;
        int  stall;
        bit  burst;
        cyc   = 0;
        burst = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            cyc++;
            if (cyc % 256 == 0) burst = ($urandom_range(0, 2) == 0);
            if (!held_off && sb.n_checked >= 150) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (!burst && $urandom_range(0, 99) < 20) begin
                stall = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                    : $urandom_range(1, 3);
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

    initial begin : tx_side
        int n_directed;
        int episode;
        sb = new();
        n_sent   = 0;
        tx_burst = 1'b0;
        held_off = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // cartridge routing, external RAM enable both ways
        issue(ACT_READ,  16'h0000, 8'h00, 8'h00, 1'b0, 8'hA5);
        issue(ACT_READ,  16'h7FFF, 8'h00, 8'hFF, 1'b1, 8'h5A);
        issue(ACT_WRITE, 16'h7FFF, 8'hFF, 8'h00, 1'b0, 8'h00);
        issue(ACT_READ,  16'hA000, 8'h00, 8'h00, 1'b1, 8'h3C);
        issue(ACT_WRITE, 16'hBFFF, 8'hFF, 8'h00, 1'b0, 8'h00);
        issue(ACT_READ,  16'hBFFF, 8'h00, 8'h00, 1'b0, 8'hC3);
        issue(ACT_READ,  16'hBFFF, 8'h00, 8'h00, 1'b1, 8'h00);
        issue(ACT_WRITE, 16'hFFFF, 8'hFF, 8'h00, 1'b1, 8'hFF);
        issue(ACT_READ,  16'hFFFF, 8'h00, 8'h00, 1'b0, 8'h00);
        // joypad: both groups, no change, change, then each group alone
        issue(ACT_WRITE, ADDR_JOYP, 8'hCF, 8'h00, 1'b0, 8'h00);
        issue(ACT_READ,  ADDR_JOYP, 8'h00, 8'hFF, 1'b0, 8'h00);
        issue(ACT_READ,  ADDR_JOYP, 8'h00, 8'h00, 1'b0, 8'h00);
        issue(ACT_WRITE, ADDR_JOYP, 8'h10, 8'h00, 1'b0, 8'h00);
        issue(ACT_READ,  ADDR_JOYP, 8'h00, 8'hF0, 1'b0, 8'h00);
        issue(ACT_WRITE, ADDR_JOYP, 8'h20, 8'h00, 1'b0, 8'h00);
        issue(ACT_READ,  ADDR_JOYP, 8'h00, 8'h0F, 1'b0, 8'h00);
        // IF priority, DIV clear, LY ignored
        issue(ACT_WRITE, ADDR_IF,  8'h1F, 8'h00, 1'b0, 8'h00);
        issue(ACT_WRITE, ADDR_IF,  8'h00, 8'h00, 1'b0, 8'h00);
        issue(ACT_WRITE, ADDR_DIV, 8'hAB, 8'h00, 1'b0, 8'h00);
        issue(ACT_READ,  ADDR_DIV, 8'h00, 8'h00, 1'b0, 8'h00);
        issue(ACT_WRITE, ADDR_LY,  8'h55, 8'h00, 1'b0, 8'h00);
        issue(ACT_READ,  ADDR_LY,  8'h00, 8'h00, 1'b0, 8'h00);
        // nop must not start DMA; idle tick
        issue(ACT_NOP,   ADDR_DMA, 8'h80, 8'hFF, 1'b1, 8'hFF);
        issue(ACT_TICK,  16'h0000, 8'h00, 8'h00, 1'b0, 8'h00);
        // DMA from work RAM with blocked and high-RAM accesses meanwhile
        issue(ACT_WRITE, 16'hC09F, 8'h88, 8'h00, 1'b0, 8'h00);
        issue(ACT_WRITE, ADDR_DMA, 8'hC0, 8'h00, 1'b0, 8'h00);
        issue(ACT_READ,  16'hC09F, 8'h00, 8'h00, 1'b0, 8'h00);
        issue(ACT_WRITE, 16'h0100, 8'h12, 8'h00, 1'b1, 8'h00);
        issue(ACT_WRITE, 16'hFF80, 8'h11, 8'h00, 1'b0, 8'h00);
        issue(ACT_READ,  16'hFF80, 8'h00, 8'h00, 1'b0, 8'h00);
        n_directed = n_sent;

        episode = 0;
        while (n_sent < n_directed + RANDOM_ITEMS) begin
            tx_burst = ($urandom_range(0, 3) == 0);
            if (episode == 0 || $urandom_range(0, 99) < 35)
                dma_episode();
            else
                traffic_episode();
            episode++;
            if (episode == 5) begin
                s_tvalid <= 1'b0;
                while (sb.pending() != 0) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
